/* hw/rtl/espid_pkg.sv */
package espid_pkg;

  localparam int PULSES_PER_REV     = 11;
  localparam int EDGE_MULTIPLIER    = 4;
  localparam int SAMPLES_PER_SECOND = 10;

  localparam int COUNT_W  = 16;
  localparam int REG_W    = 16;
  localparam int LIMIT_W  = 15;
  localparam int SPEED_W  = 22;
  localparam int ERR_W    = SPEED_W + 1;
  localparam int SUM_W    = 16;
  localparam int DERR_W   = ERR_W + 1;
  localparam int GEAR_W   = 2;
  localparam int CFG_IDX_W = 3;

  // speed = trunc(step * SPEED_NUM / SPEED_DEN), divide done by reciprocal
  localparam int SPEED_NUM   = 256 * SAMPLES_PER_SECOND;
  localparam int SPEED_DEN   = PULSES_PER_REV * EDGE_MULTIPLIER;
  localparam int MAG_W       = COUNT_W + $clog2(SPEED_NUM + 1);
  localparam int RECIP_SHIFT = MAG_W + $clog2(SPEED_DEN) + 1;
  localparam longint RECIP_VAL =
      ((longint'(1) << RECIP_SHIFT) + SPEED_DEN - 1) / SPEED_DEN;
  localparam int RECIP_W     = $clog2(RECIP_VAL + 1);
  localparam int PROD_W      = MAG_W + RECIP_W;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

  localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_VAL);
  localparam logic [MAG_W-1:0]   SPEED_MUL = MAG_W'(SPEED_NUM);
  localparam logic [QUOT_W-1:0]  SPEED_POS_MAX = QUOT_W'((1 << (SPEED_W - 1)) - 1);
  localparam logic [QUOT_W-1:0]  SPEED_NEG_MAX = QUOT_W'(1 << (SPEED_W - 1));

  localparam int P_W   = REG_W + 1 + ERR_W;
  localparam int I_W   = REG_W + 1 + SUM_W;
  localparam int D_W   = REG_W + 1 + DERR_W;
  localparam int ACC_W = D_W + 2;
  localparam int FRAC_W = 16;

  localparam logic [GEAR_W-1:0] GEAR_ONE   = 2'd1;
  localparam logic [GEAR_W-1:0] GEAR_TWO   = 2'd2;
  localparam logic [GEAR_W-1:0] GEAR_THREE = 2'd3;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_GEAR = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_GEAR_ONE   = 3'd0,
    REG_TARGET_GEAR_TWO   = 3'd1,
    REG_TARGET_GEAR_THREE = 3'd2,
    REG_GAIN_PROPORTIONAL = 3'd3,
    REG_GAIN_INTEGRAL     = 3'd4,
    REG_GAIN_DERIVATIVE   = 3'd5,
    REG_INTEGRAL_LIMIT    = 3'd6,
    REG_OUTPUT_MAX        = 3'd7
  } cfg_reg_t;

  localparam logic [REG_W-1:0]   RST_TARGET_GEAR_ONE   = 16'd256;
  localparam logic [REG_W-1:0]   RST_TARGET_GEAR_TWO   = 16'd384;
  localparam logic [REG_W-1:0]   RST_TARGET_GEAR_THREE = 16'd512;
  localparam logic [REG_W-1:0]   RST_GAIN_PROPORTIONAL = 16'd15360;
  localparam logic [REG_W-1:0]   RST_GAIN_INTEGRAL     = 16'd2560;
  localparam logic [REG_W-1:0]   RST_GAIN_DERIVATIVE   = 16'd768;
  localparam logic [LIMIT_W-1:0] RST_INTEGRAL_LIMIT    = 15'd7680;
  localparam logic [REG_W-1:0]   RST_OUTPUT_MAX        = 16'd1000;

endpackage

/* hw/rtl/espid_in_if.sv */
interface espid_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [espid_pkg::COUNT_W-1:0] encoder_count;

  modport source (output valid, output func, output encoder_count, input ready);
  modport sink (input valid, input func, input encoder_count, output ready);
endinterface

/* hw/rtl/espid_out_if.sv */
interface espid_out_if;
  logic                                valid;
  logic                                ready;
  logic [espid_pkg::REG_W-1:0]         duty;
  logic signed [espid_pkg::SPEED_W-1:0] speed;
  logic [espid_pkg::GEAR_W-1:0]        gear_now;

  modport source (output valid, output duty, output speed, output gear_now, input ready);
  modport sink (input valid, input duty, input speed, input gear_now, output ready);
endinterface

/* hw/rtl/espid_cfg_if.sv */
interface espid_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [espid_pkg::CFG_IDX_W-1:0] index;
  logic [espid_pkg::REG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/encoder_speed_pid_controller.sv */
// Encoder speed PID controller.
// sample: one beat per control tick (func = 0, with the raw encoder count) or
//   per gear-step press (func = 1). Accepted when valid and ready are high.
// result: exactly one beat per sample beat, in order: clamped duty, measured
//   signed Q14.8 speed and the gear selected after that sample.
// cfg: register writes (index 0..7: three gear targets, Kp, Ki, Kd, integral
//   limit, output max). Always ready; write only while the block is empty.
// Throughput: one sample per cycle while results are taken. Five register
//   stages (count delta, reciprocal divide, error and integral update, gain
//   multiplies, sum and clamp); the previous-count update in the first stage,
//   the integral, previous-error and gear updates in the third and the held
//   duty in the last feed back, each closing within its own stage.
// Stall: each stage advances when it is empty or the next one moves, so the
//   block keeps taking samples into empty stages while a result waits; when
//   all stages hold items, sample.ready drops.
// Reset (rst, synchronous): stages empty, gear 1, integral, previous error,
//   previous count and held outputs zero, registers to their default values.
module encoder_speed_pid_controller (
  input  logic              clk,
  input  logic              rst,
  espid_in_if.sink          sample,
  espid_out_if.source       result,
  espid_cfg_if.sink         cfg
);

  // configuration registers
  logic [espid_pkg::REG_W-1:0]   target_gear_one;
  logic [espid_pkg::REG_W-1:0]   target_gear_two;
  logic [espid_pkg::REG_W-1:0]   target_gear_three;
  logic [espid_pkg::REG_W-1:0]   gain_proportional;
  logic [espid_pkg::REG_W-1:0]   gain_integral;
  logic [espid_pkg::REG_W-1:0]   gain_derivative;
  logic [espid_pkg::LIMIT_W-1:0] integral_limit;
  logic [espid_pkg::REG_W-1:0]   output_max;

  // controller state
  logic [espid_pkg::COUNT_W-1:0]       last_count;
  logic signed [espid_pkg::ERR_W-1:0]  last_error;
  logic signed [espid_pkg::SUM_W-1:0]  error_sum;
  logic [espid_pkg::GEAR_W-1:0]        gear_sel;
  logic [espid_pkg::REG_W-1:0]         duty_held;
  logic signed [espid_pkg::SPEED_W-1:0] speed_held;

  // stage valids and enables
  logic a_v, b_v, c_v, d_v, o_v;
  logic en_a, en_b, en_c, en_d, en_o;

  // stage payloads
  logic                                 a_func;
  logic signed [espid_pkg::COUNT_W-1:0] a_step;
  logic                                 b_func;
  logic signed [espid_pkg::SPEED_W-1:0] b_speed;
  logic                                 c_func;
  logic [espid_pkg::GEAR_W-1:0]         c_gear;
  logic signed [espid_pkg::SPEED_W-1:0] c_speed;
  logic signed [espid_pkg::ERR_W-1:0]   c_err;
  logic signed [espid_pkg::SUM_W-1:0]   c_sum;
  logic signed [espid_pkg::DERR_W-1:0]  c_derr;
  logic                                 d_func;
  logic [espid_pkg::GEAR_W-1:0]         d_gear;
  logic signed [espid_pkg::SPEED_W-1:0] d_speed;
  logic signed [espid_pkg::P_W-1:0]     d_p;
  logic signed [espid_pkg::I_W-1:0]     d_i;
  logic signed [espid_pkg::D_W-1:0]     d_d;
  logic [espid_pkg::REG_W-1:0]          o_duty;
  logic signed [espid_pkg::SPEED_W-1:0] o_speed;
  logic [espid_pkg::GEAR_W-1:0]         o_gear;

  assign en_o = !o_v || result.ready;
  assign en_d = !d_v || en_o;
  assign en_c = !c_v || en_d;
  assign en_b = !b_v || en_c;
  assign en_a = !a_v || en_b;

  assign sample.ready = en_a;
  assign cfg.ready    = 1'b1;

  assign result.valid    = o_v;
  assign result.duty     = o_duty;
  assign result.speed    = o_speed;
  assign result.gear_now = o_gear;

  logic accept;
  assign accept = sample.valid && en_a;

  // stage B: magnitude times reciprocal
  logic [espid_pkg::MAG_W-1:0]          b_mag;
  logic [espid_pkg::PROD_W-1:0]         b_prod;
  logic [espid_pkg::QUOT_W-1:0]         b_quot;
  logic                                 b_neg;
  logic signed [espid_pkg::SPEED_W-1:0] b_speed_next;

  assign b_neg  = a_step[espid_pkg::COUNT_W-1];
  assign b_mag  = (b_neg ? espid_pkg::MAG_W'(-$signed({a_step[espid_pkg::COUNT_W-1], a_step}))
                         : espid_pkg::MAG_W'(a_step)) * espid_pkg::SPEED_MUL;
  assign b_prod = espid_pkg::PROD_W'(b_mag) * espid_pkg::PROD_W'(espid_pkg::RECIP);
  assign b_quot = b_prod[espid_pkg::PROD_W-1:espid_pkg::RECIP_SHIFT];

  always_comb begin
    priority if (b_neg && b_quot >= espid_pkg::SPEED_NEG_MAX) begin
      b_speed_next = $signed(espid_pkg::SPEED_W'(espid_pkg::SPEED_NEG_MAX));
    end else if (b_neg) begin
      b_speed_next = -$signed(espid_pkg::SPEED_W'(b_quot));
    end else if (b_quot > espid_pkg::SPEED_POS_MAX) begin
      b_speed_next = $signed(espid_pkg::SPEED_W'(espid_pkg::SPEED_POS_MAX));
    end else begin
      b_speed_next = $signed(espid_pkg::SPEED_W'(b_quot));
    end
  end

  // stage C: error, clamped integral, derivative term
  logic [espid_pkg::REG_W-1:0]           target;
  logic signed [espid_pkg::ERR_W-1:0]    c_err_next;
  logic signed [espid_pkg::ERR_W+1:0]    c_acc_sum;
  logic signed [espid_pkg::ERR_W+1:0]    c_lim;
  logic signed [espid_pkg::SUM_W-1:0]    c_sum_next;
  logic signed [espid_pkg::DERR_W-1:0]   c_derr_next;
  logic [espid_pkg::GEAR_W-1:0]          gear_next;

  always_comb begin
    unique case (gear_sel)
      espid_pkg::GEAR_TWO:   target = target_gear_two;
      espid_pkg::GEAR_THREE: target = target_gear_three;
      default:               target = target_gear_one;
    endcase
    unique case (gear_sel)
      espid_pkg::GEAR_ONE: gear_next = espid_pkg::GEAR_TWO;
      espid_pkg::GEAR_TWO: gear_next = espid_pkg::GEAR_THREE;
      default:             gear_next = espid_pkg::GEAR_ONE;
    endcase
  end

  assign c_err_next  = $signed({1'b0, {(espid_pkg::ERR_W - espid_pkg::REG_W - 1){1'b0}}, target})
                       - espid_pkg::ERR_W'(b_speed);
  assign c_acc_sum   = (espid_pkg::ERR_W + 2)'(error_sum) + (espid_pkg::ERR_W + 2)'(c_err_next);
  assign c_lim       = $signed((espid_pkg::ERR_W + 2)'(integral_limit));
  assign c_derr_next = espid_pkg::DERR_W'(c_err_next) - espid_pkg::DERR_W'(last_error);

  always_comb begin
    priority if (c_acc_sum > c_lim) begin
      c_sum_next = espid_pkg::SUM_W'(c_lim);
    end else if (c_acc_sum < -c_lim) begin
      c_sum_next = espid_pkg::SUM_W'(-c_lim);
    end else begin
      c_sum_next = espid_pkg::SUM_W'(c_acc_sum);
    end
  end

  // stage O: sum of terms, drop fraction, clamp
  logic signed [espid_pkg::ACC_W-1:0] o_acc;
  logic [espid_pkg::REG_W-1:0]        duty_next;
  logic [espid_pkg::ACC_W-espid_pkg::FRAC_W-2:0] o_int;

  assign o_acc = espid_pkg::ACC_W'(d_p) + espid_pkg::ACC_W'(d_i) + espid_pkg::ACC_W'(d_d);
  assign o_int = o_acc[espid_pkg::ACC_W-2:espid_pkg::FRAC_W];

  always_comb begin
    priority if (o_acc[espid_pkg::ACC_W-1]) begin
      duty_next = '0;
    end else if (o_int > (espid_pkg::ACC_W - espid_pkg::FRAC_W - 1)'(output_max)) begin
      duty_next = output_max;
    end else begin
      duty_next = espid_pkg::REG_W'(o_int);
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      o_v <= 1'b0;
      last_count <= '0;
      last_error <= '0;
      error_sum  <= '0;
      gear_sel   <= espid_pkg::GEAR_ONE;
      duty_held  <= '0;
      speed_held <= '0;
      target_gear_one   <= espid_pkg::RST_TARGET_GEAR_ONE;
      target_gear_two   <= espid_pkg::RST_TARGET_GEAR_TWO;
      target_gear_three <= espid_pkg::RST_TARGET_GEAR_THREE;
      gain_proportional <= espid_pkg::RST_GAIN_PROPORTIONAL;
      gain_integral     <= espid_pkg::RST_GAIN_INTEGRAL;
      gain_derivative   <= espid_pkg::RST_GAIN_DERIVATIVE;
      integral_limit    <= espid_pkg::RST_INTEGRAL_LIMIT;
      output_max        <= espid_pkg::RST_OUTPUT_MAX;
    end else begin
      if (en_a) a_v <= sample.valid;
      if (en_b) b_v <= a_v;
      if (en_c) c_v <= b_v;
      if (en_d) d_v <= c_v;
      if (en_o) o_v <= d_v;

      if (accept && sample.func == espid_pkg::FUNC_TICK) begin
        last_count <= sample.encoder_count;
      end

      if (en_c && b_v) begin
        if (b_func == espid_pkg::FUNC_GEAR) begin
          gear_sel   <= gear_next;
          error_sum  <= '0;
          last_error <= '0;
        end else begin
          error_sum  <= c_sum_next;
          last_error <= c_err_next;
          speed_held <= b_speed;
        end
      end

      if (en_o && d_v && d_func == espid_pkg::FUNC_TICK) begin
        duty_held <= duty_next;
      end

      if (cfg.valid) begin
        unique case (espid_pkg::cfg_reg_t'(cfg.index))
          espid_pkg::REG_TARGET_GEAR_ONE:   target_gear_one   <= cfg.data;
          espid_pkg::REG_TARGET_GEAR_TWO:   target_gear_two   <= cfg.data;
          espid_pkg::REG_TARGET_GEAR_THREE: target_gear_three <= cfg.data;
          espid_pkg::REG_GAIN_PROPORTIONAL: gain_proportional <= cfg.data;
          espid_pkg::REG_GAIN_INTEGRAL:     gain_integral     <= cfg.data;
          espid_pkg::REG_GAIN_DERIVATIVE:   gain_derivative   <= cfg.data;
          espid_pkg::REG_INTEGRAL_LIMIT:    integral_limit    <= cfg.data[espid_pkg::LIMIT_W-1:0];
          espid_pkg::REG_OUTPUT_MAX:        output_max        <= cfg.data;
        endcase
      end
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en_a) begin
      a_func <= sample.func;
      a_step <= $signed(sample.encoder_count - last_count);
    end
    if (en_b) begin
      b_func  <= a_func;
      b_speed <= b_speed_next;
    end
    if (en_c) begin
      c_func  <= b_func;
      c_gear  <= (b_func == espid_pkg::FUNC_GEAR) ? gear_next : gear_sel;
      c_speed <= (b_func == espid_pkg::FUNC_GEAR) ? speed_held : b_speed;
      c_err   <= c_err_next;
      c_sum   <= c_sum_next;
      c_derr  <= c_derr_next;
    end
    if (en_d) begin
      d_func  <= c_func;
      d_gear  <= c_gear;
      d_speed <= c_speed;
      d_p <= $signed({1'b0, gain_proportional}) * c_err;
      d_i <= $signed({1'b0, gain_integral}) * c_sum;
      d_d <= $signed({1'b0, gain_derivative}) * c_derr;
    end
    if (en_o) begin
      o_duty  <= (d_func == espid_pkg::FUNC_GEAR) ? duty_held : duty_next;
      o_speed <= d_speed;
      o_gear  <= d_gear;
    end
  end

endmodule

/* tb/sv/encoder_speed_pid_controller_tb.sv */
`timescale 1ns / 100ps

module encoder_speed_pid_controller_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 250;

  typedef struct {
    logic [espid_pkg::REG_W-1:0]          duty;
    logic signed [espid_pkg::SPEED_W-1:0] speed;
    logic [espid_pkg::GEAR_W-1:0]         gear;
  } drive_beat_t;

  class pid_scoreboard;
    logic [espid_pkg::REG_W-1:0]          target_one, target_two, target_three;
    logic [espid_pkg::REG_W-1:0]          kp, ki, kd, duty_max;
    logic [espid_pkg::LIMIT_W-1:0]        sum_limit;
    logic [espid_pkg::COUNT_W-1:0]        prev_count;
    logic signed [espid_pkg::ERR_W-1:0]   prev_err;
    logic signed [espid_pkg::SUM_W-1:0]   err_sum;
    logic [espid_pkg::GEAR_W-1:0]         gear;
    logic [espid_pkg::REG_W-1:0]          duty_q;
    logic signed [espid_pkg::SPEED_W-1:0] speed_q;
    drive_beat_t                          expected[$];
    int                                   errors;

    function new();
      target_one   = espid_pkg::RST_TARGET_GEAR_ONE;
      target_two   = espid_pkg::RST_TARGET_GEAR_TWO;
      target_three = espid_pkg::RST_TARGET_GEAR_THREE;
      kp           = espid_pkg::RST_GAIN_PROPORTIONAL;
      ki           = espid_pkg::RST_GAIN_INTEGRAL;
      kd           = espid_pkg::RST_GAIN_DERIVATIVE;
      sum_limit    = espid_pkg::RST_INTEGRAL_LIMIT;
      duty_max     = espid_pkg::RST_OUTPUT_MAX;
      prev_count   = '0;
      prev_err     = '0;
      err_sum      = '0;
      gear         = espid_pkg::GEAR_ONE;
      duty_q       = '0;
      speed_q      = '0;
      errors       = 0;
    endfunction

    function void set_reg(espid_pkg::cfg_reg_t idx, logic [espid_pkg::REG_W-1:0] v);
      case (idx)
        espid_pkg::REG_TARGET_GEAR_ONE:   target_one = v;
        espid_pkg::REG_TARGET_GEAR_TWO:   target_two = v;
        espid_pkg::REG_TARGET_GEAR_THREE: target_three = v;
        espid_pkg::REG_GAIN_PROPORTIONAL: kp = v;
        espid_pkg::REG_GAIN_INTEGRAL:     ki = v;
        espid_pkg::REG_GAIN_DERIVATIVE:   kd = v;
        espid_pkg::REG_INTEGRAL_LIMIT:    sum_limit = v[espid_pkg::LIMIT_W-1:0];
        espid_pkg::REG_OUTPUT_MAX:        duty_max = v;
        default: ;
      endcase
    endfunction

    function void note_sample(logic f, logic [espid_pkg::COUNT_W-1:0] c);
      logic [espid_pkg::COUNT_W-1:0] delta;
      longint step, spd, err, total, lim, acc, q, tgt;
      drive_beat_t b;
      if (f == espid_pkg::FUNC_GEAR) begin
        case (gear)
          espid_pkg::GEAR_ONE: gear = espid_pkg::GEAR_TWO;
          espid_pkg::GEAR_TWO: gear = espid_pkg::GEAR_THREE;
          default:             gear = espid_pkg::GEAR_ONE;
        endcase
        err_sum  = '0;
        prev_err = '0;
      end else begin
        delta = c - prev_count;
        step = longint'($signed(delta));
        prev_count = c;
        spd = (step * 256 * espid_pkg::SAMPLES_PER_SECOND)
            / (espid_pkg::PULSES_PER_REV * espid_pkg::EDGE_MULTIPLIER);
        if (spd > longint'(2097151)) spd = 2097151;
        if (spd < -longint'(2097152)) spd = -2097152;
        case (gear)
          espid_pkg::GEAR_TWO:   tgt = longint'(target_two);
          espid_pkg::GEAR_THREE: tgt = longint'(target_three);
          default:               tgt = longint'(target_one);
        endcase
        err = tgt - spd;
        lim = longint'(sum_limit);
        total = longint'(err_sum) + err;
        if (total > lim) total = lim;
        if (total < -lim) total = -lim;
        acc = longint'(kp) * err + longint'(ki) * total
            + longint'(kd) * (err - longint'(prev_err));
        q = acc / 65536;
        if (q < 0) q = 0;
        if (q > longint'(duty_max)) q = longint'(duty_max);
        err_sum  = total[espid_pkg::SUM_W-1:0];
        prev_err = err[espid_pkg::ERR_W-1:0];
        duty_q   = q[espid_pkg::REG_W-1:0];
        speed_q  = spd[espid_pkg::SPEED_W-1:0];
      end
      b.duty  = duty_q;
      b.speed = speed_q;
      b.gear  = gear;
      expected.push_back(b);
    endfunction

    function void check_result(logic [espid_pkg::REG_W-1:0] duty,
                               logic signed [espid_pkg::SPEED_W-1:0] speed,
                               logic [espid_pkg::GEAR_W-1:0] gear_now);
      drive_beat_t b;
      if (expected.size() == 0) begin
        $error("result beat with no sample pending: duty %0d speed %0d gear %0d",
               duty, speed, gear_now);
        errors++;
        return;
      end
      b = expected.pop_front();
      if (duty !== b.duty) begin
        $error("duty: expected %0d, actual %0d", b.duty, duty);
        errors++;
      end
      if (speed !== b.speed) begin
        $error("speed: expected %0d, actual %0d", b.speed, speed);
        errors++;
      end
      if (gear_now !== b.gear) begin
        $error("gear_now: expected %0d, actual %0d", b.gear, gear_now);
        errors++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  espid_in_if  in_bus ();
  espid_out_if res_bus ();
  espid_cfg_if cfg_bus ();

  encoder_speed_pid_controller u_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (in_bus),
    .result (res_bus),
    .cfg    (cfg_bus)
  );

  pid_scoreboard                 sb;
  int                            in_idle_pct  = 0;
  int                            out_idle_pct = 0;
  int                            hold_len     = 0;
  int                            cycle_count  = 0;
  logic [espid_pkg::COUNT_W-1:0] gen_count    = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("encoder_speed_pid_controller: mismatch");
      $finish;
    end
  end

  initial begin : drain
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_bus.valid && res_bus.ready)
        sb.check_result(res_bus.duty, res_bus.speed, res_bus.gear_now);
      if (hold_len > 0) begin
        res_bus.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      res_bus.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic send_sample(input logic f, input logic [espid_pkg::COUNT_W-1:0] c);
    while ($urandom_range(99) < in_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.func          <= f;
    in_bus.encoder_count <= c;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_sample(f, c);
    if (f == espid_pkg::FUNC_TICK) gen_count = c;
  endtask

  task automatic write_reg(input espid_pkg::cfg_reg_t idx,
                           input logic [espid_pkg::REG_W-1:0] v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.set_reg(idx, v);
  endtask

  task automatic quiesce();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_random();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8)
      send_sample(espid_pkg::FUNC_GEAR, espid_pkg::COUNT_W'($urandom));
    else if (pick < 70)
      send_sample(espid_pkg::FUNC_TICK, gen_count + espid_pkg::COUNT_W'($urandom_range(40))
                  - espid_pkg::COUNT_W'(8));
    else if (pick < 85)
      send_sample(espid_pkg::FUNC_TICK, gen_count + espid_pkg::COUNT_W'($urandom_range(4095))
                  - espid_pkg::COUNT_W'(2048));
    else
      send_sample(espid_pkg::FUNC_TICK, espid_pkg::COUNT_W'($urandom));
  endtask

  initial begin : stimulus
    logic [espid_pkg::REG_W-1:0] v;
    sb = new();
    rst                  <= 1'b1;
    in_bus.valid         <= 1'b0;
    in_bus.func          <= espid_pkg::FUNC_TICK;
    in_bus.encoder_count <= '0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= espid_pkg::REG_TARGET_GEAR_ONE;
    cfg_bus.data         <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // gear step before any tick, then cycle back to gear one
    send_sample(espid_pkg::FUNC_GEAR, 16'hFFFF);
    send_sample(espid_pkg::FUNC_TICK, 16'h0000);
    send_sample(espid_pkg::FUNC_GEAR, 16'h0000);
    send_sample(espid_pkg::FUNC_GEAR, 16'h1234);
    send_sample(espid_pkg::FUNC_TICK, 16'h0004);
    send_sample(espid_pkg::FUNC_TICK, 16'h0009);
    // largest forward step: speed far above target, duty floors at zero
    send_sample(espid_pkg::FUNC_TICK, 16'h8008);
    send_sample(espid_pkg::FUNC_TICK, 16'h8008);
    // largest backward step: integral clamps high, duty hits its ceiling
    send_sample(espid_pkg::FUNC_TICK, 16'h0008);
    send_sample(espid_pkg::FUNC_TICK, 16'hFFFF);
    // step forward across the counter wrap
    send_sample(espid_pkg::FUNC_TICK, 16'h0003);
    send_sample(espid_pkg::FUNC_TICK, 16'h0000);
    send_sample(espid_pkg::FUNC_TICK, 16'hFFFF);
    send_sample(espid_pkg::FUNC_TICK, 16'h0004);
    send_sample(espid_pkg::FUNC_GEAR, 16'h0000);
    send_sample(espid_pkg::FUNC_TICK, 16'h000A);
    send_sample(espid_pkg::FUNC_GEAR, 16'h0000);
    send_sample(espid_pkg::FUNC_TICK, 16'h0013);
    send_sample(espid_pkg::FUNC_TICK, 16'h001C);
    send_sample(espid_pkg::FUNC_GEAR, 16'h0000);
    send_sample(espid_pkg::FUNC_TICK, 16'h7FFF);
    send_sample(espid_pkg::FUNC_TICK, 16'h8000);

    for (int phase = 0; phase < 6; phase++) begin
      quiesce();
      for (int r = 0; r < 8; r++) begin
        case (phase)
          1: v = '0;
          3: v = '1;
          4: begin
            case (espid_pkg::cfg_reg_t'(r))
              espid_pkg::REG_TARGET_GEAR_ONE:   v = espid_pkg::RST_TARGET_GEAR_ONE;
              espid_pkg::REG_TARGET_GEAR_TWO:   v = espid_pkg::RST_TARGET_GEAR_TWO;
              espid_pkg::REG_TARGET_GEAR_THREE: v = espid_pkg::RST_TARGET_GEAR_THREE;
              espid_pkg::REG_GAIN_PROPORTIONAL: v = espid_pkg::RST_GAIN_PROPORTIONAL;
              espid_pkg::REG_GAIN_INTEGRAL:     v = espid_pkg::RST_GAIN_INTEGRAL;
              espid_pkg::REG_GAIN_DERIVATIVE:   v = espid_pkg::RST_GAIN_DERIVATIVE;
              espid_pkg::REG_INTEGRAL_LIMIT:
                v = espid_pkg::REG_W'(espid_pkg::RST_INTEGRAL_LIMIT);
              default:                          v = espid_pkg::RST_OUTPUT_MAX;
            endcase
          end
          default: begin
            if (r <= int'(espid_pkg::REG_TARGET_GEAR_THREE))
              v = espid_pkg::REG_W'($urandom_range(2047));
            else
              v = espid_pkg::REG_W'($urandom);
          end
        endcase
        write_reg(espid_pkg::cfg_reg_t'(r), v);
      end
      cfg_bus.valid <= 1'b0;

      if (phase < 2) begin
        in_idle_pct  = 12;
        out_idle_pct = 57;
      end else if (phase < 4) begin
        in_idle_pct  = 57;
        out_idle_pct = 12;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // hold the result side long enough to back up every stage
        if (i == 100 && (phase == 1 || phase == 4)) hold_len = 60;
        if (i == 120 && phase == 3) quiesce();
        send_random();
      end
    end

    quiesce();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("encoder_speed_pid_controller: match");
    else
      $display("encoder_speed_pid_controller: mismatch");
    $finish;
  end

endmodule
